// ----- rtl/hcc_pkg.sv -----
// Package for the hash collision counter: field widths, limits and command codes.
// No dependencies; every other file in the block depends on it.
package hcc_pkg;

    localparam int MAX_HASHES = 64;
    localparam int INDEX_W    = $clog2(MAX_HASHES);
    localparam int VALUE_W    = 32;
    localparam int POINT_W    = 16;
    localparam int COUNT_W    = 7;
    localparam int HCOUNT_W   = 7;

    // Largest running count and largest point ordinal.
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [POINT_W-1:0] POINT_LIMIT = {POINT_W{1'b1}};

    typedef enum logic
    {
        CMD_QUERY = 1'b0,
        CMD_POINT = 1'b1
    } cmd_t;

endpackage

// ----- rtl/hcc_if.sv -----
// Valid/ready stream interfaces for the hash collision counter.
// Depends on hcc_pkg for the payload types and widths.
interface hcc_in_if;
    logic                               valid;
    logic                               ready;
    hcc_pkg::cmd_t                      cmd;
    logic [hcc_pkg::INDEX_W-1:0]        hash_index;
    logic signed [hcc_pkg::VALUE_W-1:0] hash_value;

    modport source (output valid, output cmd, output hash_index, output hash_value,
                    input ready);
    modport sink   (input valid, input cmd, input hash_index, input hash_value,
                    output ready);
endinterface

interface hcc_out_if;
    logic                        valid;
    logic                        ready;
    logic [hcc_pkg::POINT_W-1:0] point_index;
    logic [hcc_pkg::COUNT_W-1:0] match_count;

    modport source (output valid, output point_index, output match_count, input ready);
    modport sink   (input valid, input point_index, input match_count, output ready);
endinterface

// ----- rtl/hash_collision_counter_top.sv -----
// Top level of the hash collision counter: query store, compare stage, result register.
// Depends on hcc_pkg and the stream interfaces in hcc_if.sv.
//
// Usage:
//   item   - sink channel. cmd = CMD_QUERY stores hash_value as the query's bucket
//            number for hash_index and restarts the point ordinal; cmd = CMD_POINT
//            streams one bucket number of a data point, hash indices in order.
//   result - source channel. One transaction per data point, issued after the hash at
//            index hash_count - 1: the point ordinal (saturates at 65535) and the
//            number of hash functions where point and query collide.
//   cfg_we / cfg_wdata - write of hash_count (0 acts as 1, above 64 acts as 64).
//            Write only while the block is idle.
// Timing:
//   One transaction per cycle on item while item.ready is high. Stage 1 registers the
//   item together with the query store read at its hash_index; stage 2 compares and
//   updates the running count, loading the result register on a point's last hash. The
//   single-cycle rate is set by the one read port of the query store and the count
//   update loop.
// Reset: clears the pipeline valids, counts and ordinal; hash_count returns to 64.
//   The query store is not cleared and must be loaded before points are streamed.
// Stall: while result is held, items that produce no result still drain; item.ready
//   drops only when a finished point waits in stage 1 behind a held result.
module hash_collision_counter_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [hcc_pkg::HCOUNT_W-1:0] cfg_wdata,
    hcc_in_if.sink                       item,
    hcc_out_if.source                    result
);
    import hcc_pkg::*;

    logic [VALUE_W-1:0] query_mem [MAX_HASHES];

    logic [INDEX_W-1:0] last_reg;
    logic [INDEX_W-1:0] last_next;

    // Stage 1
    logic               s1_valid_reg;
    cmd_t               s1_cmd_reg;
    logic [INDEX_W-1:0] s1_index_reg;
    logic [VALUE_W-1:0] s1_value_reg;
    logic [VALUE_W-1:0] s1_query_reg;

    // Stage 2 state
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [POINT_W-1:0] point_reg;
    logic [POINT_W-1:0] point_next;

    // Result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [POINT_W-1:0] out_point_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               item_accept;
    logic               s1_emits;
    logic               s1_go;
    logic               s1_consume;
    logic               s1_in_range;
    logic [COUNT_W-1:0] count_inc;

    // Finished point in stage 1: it needs the result register.
    assign s1_in_range = (s1_index_reg <= last_reg);
    assign s1_emits    = (s1_cmd_reg == CMD_POINT) && (s1_index_reg == last_reg);
    assign s1_go       = !s1_emits || !out_valid_reg || result.ready;
    assign s1_consume  = s1_valid_reg && s1_go;
    assign item.ready  = !s1_valid_reg || s1_go;
    assign item_accept = item.valid && item.ready;

    // Map the register write to the index of the last hash of a point.
    always_comb
    begin
        last_next = last_reg;
        if (cfg_we)
        begin
            if (cfg_wdata == '0)
                last_next = '0;
            else if (cfg_wdata > HCOUNT_W'(MAX_HASHES))
                last_next = INDEX_W'(MAX_HASHES - 1);
            else
                last_next = INDEX_W'(cfg_wdata - HCOUNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= INDEX_W'(MAX_HASHES - 1);
        else
            last_reg <= last_next;
    end

    // Query store: write on a query load, read on every accepted transaction.
    always_ff @(posedge clk)
    begin
        if (item_accept && item.cmd == CMD_QUERY)
            query_mem[item.hash_index] <= item.hash_value;
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_query_reg <= query_mem[item.hash_index];
            s1_cmd_reg   <= item.cmd;
            s1_index_reg <= item.hash_index;
            s1_value_reg <= item.hash_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item.ready)
            s1_valid_reg <= item.valid;
    end

    // Compare and count; saturate the running count at its maximum.
    assign count_inc = ((s1_query_reg == s1_value_reg) && (count_reg != COUNT_MAX))
                       ? count_reg + COUNT_W'(1) : count_reg;

    always_comb
    begin
        count_next     = count_reg;
        point_next     = point_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (s1_consume)
        begin
            case (s1_cmd_reg)
                CMD_QUERY:
                begin
                    count_next = '0;
                    point_next = '0;
                end
                CMD_POINT:
                begin
                    if (s1_emits)
                    begin
                        count_next     = '0;
                        out_valid_next = 1'b1;
                        if (point_reg != POINT_LIMIT)
                            point_next = point_reg + POINT_W'(1);
                    end
                    else if (s1_in_range)
                    begin
                        count_next = count_inc;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            point_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            point_reg     <= point_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload when a finished point leaves stage 1.
    always_ff @(posedge clk)
    begin
        if (s1_consume && s1_emits)
        begin
            out_point_reg <= point_reg;
            out_count_reg <= count_inc;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.point_index = out_point_reg;
    assign result.match_count = out_count_reg;

endmodule

// ----- rtl/hcc_checker.sv -----
// Port-level checks for the hash collision counter, bound to the top level.
// Depends on hcc_pkg and hash_collision_counter_top.
module hcc_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [hcc_pkg::POINT_W-1:0] result_point_index,
    input logic [hcc_pkg::COUNT_W-1:0] result_match_count
);
    import hcc_pkg::*;

    logic [POINT_W-1:0] last_point_reg;
    logic               result_accept;

    assign result_accept = result_valid && result_ready;

    // Hold the ordinal of the last accepted result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_point_reg <= '0;
        else if (result_accept)
            last_point_reg <= result_point_index;
    end

    // Held result keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_point_index) && $stable(result_match_count))
        else $error("result changed while stalled");

    // Input stalls only behind a held result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("item stalled without a held result");

    // Ordinals either restart from zero after a query load, advance by one, or stay at the limit.
    a_ordinal_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_accept |->
            (result_point_index == '0) ||
            (result_point_index == last_point_reg + POINT_W'(1)) ||
            (result_point_index == POINT_LIMIT && last_point_reg == POINT_LIMIT))
        else $error("point ordinal skipped");

    // A result rises only after an accepted item, an accepted result or a stalled input.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 2) ||
                                $past(result_valid && result_ready) ||
                                $past(!item_ready))
        else $error("result without a source transaction");

endmodule

bind hash_collision_counter_top hcc_checker u_hcc_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item.valid),
    .item_ready         (item.ready),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_point_index (result.point_index),
    .result_match_count (result.match_count)
);
